@@ hdl/msdw_pkg.sv @@
package msdw_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int VALUE_BITS = 32;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 7;
  localparam int SUM_W   = 38;

  // fill count holds 0..MAX_WINDOW
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  // what one cell hands to its older neighbor
  typedef struct packed {
    logic [VALUE_BITS-1:0] val;
    logic [SUM_W-1:0]      pre;   // running total before this value went in
  } link_t;

endpackage

@@ hdl/msdw_if.sv @@
interface msdw_in_if;
  logic                              valid;
  logic                              ready;
  logic [msdw_pkg::VALUE_W-1:0]      value;
  logic                              last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface msdw_out_if;
  logic                              valid;
  logic                              ready;
  logic [msdw_pkg::SUM_W-1:0]        best_sum;
  logic                              done_res;

  modport source (output valid, output best_sum, output done_res, input ready);
  modport sink   (input valid, input best_sum, input done_res, output ready);
endinterface

@@ hdl/msdw_cell.sv @@
module msdw_cell (
  input  logic                              clk,
  input  logic                              shift_en,
  input  msdw_pkg::link_t                   link_in,
  input  logic [msdw_pkg::VALUE_BITS-1:0]   key,
  output msdw_pkg::link_t                   link_out,
  output logic                              hit
);

  msdw_pkg::link_t link_r;
  msdw_pkg::link_t link_nxt;

  always_comb begin
    link_nxt = shift_en ? link_in : link_r;
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign link_out = link_r;
  // raw compare; the top gates it with the cell's valid
  assign hit      = (link_r.val == key);

endmodule

@@ hdl/max_sum_distinct_window.sv @@
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        value[31:0], last_item
// out_ch    out  valid/ready        best_sum[37:0], done_res
// cfg       in   cfg_we (no ready)  cfg_data[6:0] = window_length
//
// One item per clock while ready. The result is registered: it appears the
// cycle after the item is taken. The window update (duplicate search over
// all cells, append, trim, score) completes in the accepting cycle.
// in_ch.ready stays high while the output register is empty or being drained,
// so a stalled consumer holds at most one result before input stalls too.
// rst_n (synchronous) empties the window, zeroes the best sum and sets the
// window length to 1; no clearing pass is needed.
module max_sum_distinct_window (
  input  logic                         clk,
  input  logic                         rst_n,
  msdw_in_if.sink                      in_ch,
  msdw_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [msdw_pkg::CFG_W-1:0]   cfg_data
);

  localparam int NC = msdw_pkg::MAX_WINDOW;
  localparam int CW = msdw_pkg::CNT_W;
  localparam int SW = msdw_pkg::SUM_W;
  localparam int VB = msdw_pkg::VALUE_BITS;

  // Window layout: cell 0 holds the newest value, cell fill_r-1 the oldest.
  // Each cell also keeps the running total taken just before its value
  // entered, so the sum of the newest k values is total - pre(cell k-1).
  // Totals wrap at SUM_W bits; the difference is exact since a window sum
  // always fits.

  logic [msdw_pkg::CFG_W-1:0] wlen_r;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic [SW-1:0]              total_r, total_nxt;
  logic [SW-1:0]              best_r, best_nxt;

  logic                       out_valid_r;
  logic [SW-1:0]              out_best_r;
  logic                       out_done_r;

  logic                       accept;
  logic [VB-1:0]              key;
  msdw_pkg::link_t            link_q [NC];
  msdw_pkg::link_t            link_head;
  logic [NC-1:0]              hit;

  logic [CW-1:0]              k_eff;
  logic                       dup;
  logic [CW-1:0]              dup_idx;
  logic [CW-1:0]              fill_a, fill_b, fill_c;
  logic [SW-1:0]              pre_tap;
  logic [SW-1:0]              win_sum;
  logic                       full;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign key         = in_ch.value[VB-1:0];

  // new entry carries the total before it
  assign link_head.val = key;
  assign link_head.pre = total_r;

  // row of cells, shifting toward the old end on each item
  for (genvar i = 0; i < NC; i++) begin : g_cell
    msdw_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .link_in  ((i == 0) ? link_head : link_q[(i == 0) ? 0 : i - 1]),
      .key      (key),
      .link_out (link_q[i]),
      .hit      (hit[i])
    );
  end

  // effective window length: 0 acts as 1, clamp at the cell count
  always_comb begin
    if (wlen_r == '0) begin
      k_eff = CW'(1);
    end else if (int'(wlen_r) > NC) begin
      k_eff = CW'(NC);
    end else begin
      k_eff = CW'(wlen_r);
    end
  end

  // values in the window are distinct, so at most one valid cell hits
  always_comb begin
    dup     = 1'b0;
    dup_idx = '0;
    for (int i = 0; i < NC; i++) begin
      if (hit[i] && (CW'(i) < fill_r)) begin
        dup     = 1'b1;
        dup_idx = dup_idx | CW'(i);
      end
    end
  end

  // pre of the cell that becomes the k-th newest after the shift:
  // old cell k-2, or the current total when k is 1
  always_comb begin
    pre_tap = '0;
    for (int i = 0; i < NC; i++) begin
      if (k_eff == CW'(i + 2)) begin
        pre_tap = pre_tap | link_q[i].pre;
      end
    end
    if (k_eff == CW'(1)) begin
      pre_tap = total_r;
    end
  end

  always_comb begin
    // cut at the earlier copy, then append
    fill_a    = dup ? dup_idx : fill_r;
    fill_b    = fill_a + CW'(1);
    // trim to k if the length was lowered
    fill_c    = (fill_b > k_eff) ? k_eff : fill_b;
    full      = (fill_c == k_eff);
    total_nxt = total_r + SW'(key);
    win_sum   = total_nxt - pre_tap;

    best_nxt  = (full && (win_sum > best_r)) ? win_sum : best_r;
    // a full window scores and then loses its oldest entry
    fill_nxt  = full ? (k_eff - CW'(1)) : fill_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= msdw_pkg::CFG_W'(1);
      fill_r  <= '0;
      total_r <= '0;
      best_r  <= '0;
    end else begin
      if (cfg_we) begin
        wlen_r <= cfg_data;
      end
      if (accept) begin
        if (in_ch.last_item) begin
          // end of array: back to an empty window
          fill_r  <= '0;
          total_r <= '0;
          best_r  <= '0;
        end else begin
          fill_r  <= fill_nxt;
          total_r <= total_nxt;
          best_r  <= best_nxt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_best_r <= best_nxt;
      out_done_r <= in_ch.last_item;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.best_sum = out_best_r;
  assign out_ch.done_res = out_done_r;

  // window never holds a full set between items
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(NC))
    else $error("window fill out of range");

  // closing item empties the state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_item |=> (fill_r == '0) && (best_r == '0) && (total_r == '0))
    else $error("state not cleared after last item");

  // best sum only grows within an array
  a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.last_item |=> best_r >= $past(best_r))
    else $error("best sum decreased");

  // a result appears only for a taken item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(accept))
    else $error("result without input item");

endmodule
